### hw/rtl/mvra_pkg.sv
// Shared types, codes and mask helper for the message vector run allocator.
package mvra_pkg;

  // Width of the widest vector map and of a run mask
  localparam int MAP_W = 64;

  // Action field codes
  localparam logic ACT_OBTAIN  = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // Register select, taken from the word address bit
  localparam logic REG_VECTOR_COUNT = 1'b0;
  localparam logic REG_BASE_INTID   = 1'b1;

  // Command kinds passed from the front end to the back end
  localparam logic [1:0] CMD_RELEASE = 2'd0;
  localparam logic [1:0] CMD_FAIL    = 2'd1;
  localparam logic [1:0] CMD_ZERO    = 2'd2;
  localparam logic [1:0] CMD_OBTAIN  = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] want;
    logic [6:0] avail;
    logic [5:0] rel_start;
    logic [6:0] rel_count;
  } cmd_t;

  // Run of count ones starting at start; counts of 64 or more fill to the top
  function automatic logic [MAP_W-1:0] run_mask(input logic [5:0] start,
                                                input logic [6:0] count);
    logic [MAP_W-1:0] bits;
    if (count >= 7'(MAP_W)) begin
      bits = '1;
    end else begin
      bits = (MAP_W'(1) << count) - MAP_W'(1);
    end
    return bits << start;
  endfunction

endpackage

### hw/rtl/mvra_if.sv
// Request and response channel interfaces of the message vector run allocator.
interface mvra_req_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [6:0] request_max;
  logic [6:0] request_min;
  logic       single_only;
  logic [5:0] release_start;
  logic [6:0] release_count;

  modport source (output valid, action, request_max, request_min, single_only,
                  release_start, release_count, input ready);
  modport sink   (input valid, action, request_max, request_min, single_only,
                  release_start, release_count, output ready);
endinterface

interface mvra_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [5:0]  first_vector;
  logic [6:0]  granted;
  logic [10:0] interrupt_id;

  modport source (output valid, ok, first_vector, granted, interrupt_id, input ready);
  modport sink   (input valid, ok, first_vector, granted, interrupt_id, output ready);
endinterface

### hw/rtl/mvra_front.sv
// Front end: accepts requests and classifies them into back-end commands.
module mvra_front import mvra_pkg::*; #(
  parameter int VECTORS = 64
) (
  input  logic [6:0]  vector_count,
  mvra_req_if.sink    req,
  input  logic        full,
  output logic        push,
  output cmd_t        cmd
);

  localparam logic [6:0] VEC_LIMIT = 7'(VECTORS);

  logic [6:0] avail;
  logic [6:0] want_c;

  // Take a request whenever the queue has room
  assign req.ready = !full;
  assign push      = req.valid && !full;

  // Effective vector count and clamped request
  assign avail  = (vector_count > VEC_LIMIT) ? VEC_LIMIT : vector_count;
  assign want_c = (req.request_max > avail) ? avail : req.request_max;

  // Classify
  always_comb begin
    cmd.want      = req.single_only ? 7'd1 : want_c;
    cmd.avail     = avail;
    cmd.rel_start = req.release_start;
    cmd.rel_count = req.release_count;
    if (req.action == ACT_RELEASE) begin
      cmd.kind = CMD_RELEASE;
    end else if (avail == 7'd0 || want_c < req.request_min) begin
      cmd.kind = CMD_FAIL;
    end else if (!req.single_only && want_c == 7'd0) begin
      cmd.kind = CMD_ZERO;
    end else begin
      cmd.kind = CMD_OBTAIN;
    end
  end

endmodule

### hw/rtl/mvra_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
module mvra_cmd_fifo import mvra_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_cmd = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule

### hw/rtl/mvra_back.sv
// Back end: holds the used map, runs the first-fit scan and drives responses.
module mvra_back import mvra_pkg::*; #(
  parameter int VECTORS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [9:0]  base_intid,
  input  logic        empty,
  input  cmd_t        head,
  output logic        pop,
  mvra_rsp_if.source  rsp
);

  localparam int IW = (VECTORS > 1) ? $clog2(VECTORS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_MARK = 2'd2;

  logic [1:0]         state;
  logic [VECTORS-1:0] used_map;
  logic [6:0]         cur_want;
  logic [6:0]         cur_avail;
  logic [6:0]         pos;
  logic [6:0]         run;
  logic [5:0]         start;

  logic               out_valid;
  logic               out_ok;
  logic [5:0]         out_first;
  logic [6:0]         out_granted;
  logic [10:0]        out_intid;

  logic [MAP_W-1:0]   rel_mask;
  logic [MAP_W-1:0]   grant_mask;
  logic               map_bit;
  logic [6:0]         run_inc;
  logic               out_free;

  assign rsp.valid        = out_valid;
  assign rsp.ok           = out_ok;
  assign rsp.first_vector = out_first;
  assign rsp.granted      = out_granted;
  assign rsp.interrupt_id = out_intid;

  // Next command only when idle and the response slot frees up
  assign out_free = !out_valid || rsp.ready;
  assign pop      = (state == ST_IDLE) && !empty && out_free;

  assign rel_mask   = run_mask(head.rel_start, head.rel_count);
  assign grant_mask = run_mask(start, cur_want);
  assign map_bit    = used_map[pos[IW-1:0]];
  assign run_inc    = run + 7'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      used_map  <= '0;
    end else begin
      // A dispatch in the same cycle decides the slot itself
      if (out_valid && rsp.ready && !pop) out_valid <= 1'b0;
      unique case (state)
        // Dispatch a command from the queue
        ST_IDLE: begin
          if (pop) begin
            cur_want  <= head.want;
            cur_avail <= head.avail;
            pos       <= 7'd0;
            run       <= 7'd0;
            unique case (head.kind)
              CMD_RELEASE: begin
                used_map    <= used_map & ~rel_mask[VECTORS-1:0];
                out_valid   <= 1'b1;
                out_ok      <= 1'b1;
                out_first   <= 6'd0;
                out_granted <= 7'd0;
                out_intid   <= 11'd0;
              end
              CMD_FAIL: begin
                out_valid   <= 1'b1;
                out_ok      <= 1'b0;
                out_first   <= 6'd0;
                out_granted <= 7'd0;
                out_intid   <= 11'd0;
              end
              CMD_ZERO: begin
                out_valid   <= 1'b1;
                out_ok      <= 1'b1;
                out_first   <= 6'd0;
                out_granted <= 7'd0;
                out_intid   <= {1'b0, base_intid};
              end
              CMD_OBTAIN: begin
                out_valid <= 1'b0;
                state     <= ST_SCAN;
              end
              default: begin
                out_valid <= 1'b0;
                state     <= ST_IDLE;
              end
            endcase
          end
        end
        // One vector per cycle, tracking the current free run length
        ST_SCAN: begin
          if (pos == cur_avail) begin
            out_valid   <= 1'b1;
            out_ok      <= 1'b0;
            out_first   <= 6'd0;
            out_granted <= 7'd0;
            out_intid   <= 11'd0;
            state       <= ST_IDLE;
          end else if (!map_bit && run_inc == cur_want) begin
            start <= 6'(pos + 7'd1 - cur_want);
            state <= ST_MARK;
          end else begin
            pos <= pos + 7'd1;
            run <= map_bit ? 7'd0 : run_inc;
          end
        end
        // Mark the found run and report it
        ST_MARK: begin
          used_map    <= used_map | grant_mask[VECTORS-1:0];
          out_valid   <= 1'b1;
          out_ok      <= 1'b1;
          out_first   <= start;
          out_granted <= cur_want;
          out_intid   <= {1'b0, base_intid} + {5'd0, start};
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/msi_vector_run_allocator.sv
// Top level of the message vector run allocator: registers and front/back wiring.
//
//   port      dir   handshake          moves
//   req       in    valid/ready        obtain or release request
//   rsp       out   valid/ready        one response per request
//   APB       in    psel/penable       vector_count (0x0), base_intid (0x4)
//
// A request enters the command queue in the cycle it is accepted; the back end
// takes it in the next cycle at the earliest. Release, failed and zero-count
// requests are answered straight from the dispatch step; an obtain scans the map
// one vector per cycle, then marks the run that it found or reports a failure.
// Synchronous reset clears the map, the queue and the registers to defaults.
// Requests are taken while the queue has room, even with a response stalled.
module msi_vector_run_allocator import mvra_pkg::*; #(
  parameter int VECTORS = 64
) (
  input  logic        clk,
  input  logic        rst,
  mvra_req_if.sink    req,
  mvra_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0] vector_count;
  logic [9:0] base_intid;
  logic       cfg_write;

  logic       full;
  logic       push;
  cmd_t       push_cmd;
  logic       empty;
  logic       pop;
  cmd_t       head;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_count <= 7'd64;
      base_intid   <= 10'd0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_VECTOR_COUNT: vector_count <= pwdata[6:0];
        REG_BASE_INTID:   base_intid   <= pwdata[9:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_VECTOR_COUNT: prdata = {25'd0, vector_count};
      REG_BASE_INTID:   prdata = {22'd0, base_intid};
      default:          prdata = 32'd0;
    endcase
  end

  mvra_front #(.VECTORS(VECTORS)) u_front (
    .vector_count (vector_count),
    .req          (req),
    .full         (full),
    .push         (push),
    .cmd          (push_cmd)
  );

  mvra_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (head),
    .empty    (empty)
  );

  mvra_back #(.VECTORS(VECTORS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .base_intid (base_intid),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule
